// ===== hw/rtl/bat_pkg.sv =====
// Shared constants, types and transposition helpers for the braid action block.
package bat_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int POINT_BITS  = 4;
	localparam int IDX_BITS    = 4;
	localparam int LEN_BITS    = 5;
	localparam int MOVE_BITS   = 8;
	localparam int STEP_BITS   = 8;

	localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(2);
	localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_ENTRIES);
	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_BRAID = 1'b1;

	// table write source
	localparam logic [1:0] WR_INPUT = 2'd0;
	localparam logic [1:0] WR_STEP  = 2'd1;
	localparam logic [1:0] WR_MOVED = 2'd2;

	// table read address source
	localparam logic [1:0] RD_START = 2'd0;
	localparam logic [1:0] RD_NEXT  = 2'd1;
	localparam logic [1:0] RD_EMIT  = 2'd2;

	typedef struct packed {
		logic [POINT_BITS-1:0] lo;
		logic [POINT_BITS-1:0] hi;
	} pair_t;

	typedef struct packed {
		logic                 cmd;
		logic [IDX_BITS-1:0]  entry_index;
		logic [POINT_BITS-1:0] point_a;
		logic [POINT_BITS-1:0] point_b;
		logic [IDX_BITS-1:0]  start_index;
		logic [MOVE_BITS-1:0] move_count;
		logic                 over_flag;
	} in_word_t;

	typedef struct packed {
		logic       wr_en;
		logic [1:0] wr_sel;
		logic [1:0] rd_sel;
		logic       load_braid;
		logic       load_m;
		logic       step;
		logic       clr_k;
		logic       inc_k;
		logic       out_load;
		logic       out_bad;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cmd;
		logic idx_bad;
		logic steps_zero;
		logic steps_one;
		logic emit_last;
		logic out_busy;
		logic out_free;
	} ctrl_stat_t;

	function automatic pair_t order_pair(input pair_t p);
		pair_t r;
		if (p.lo > p.hi) begin
			r.lo = p.hi;
			r.hi = p.lo;
		end else begin
			r = p;
		end
		return r;
	endfunction

	// Rename the points of x through the transposition y, then reorder.
	function automatic pair_t conj(input pair_t x, input pair_t y);
		pair_t r;
		r = x;
		if (x.lo == y.lo) r.lo = y.hi;
		if (x.lo == y.hi) r.lo = y.lo;
		if (x.hi == y.lo) r.hi = y.hi;
		if (x.hi == y.hi) r.hi = y.lo;
		return order_pair(r);
	endfunction

endpackage

// ===== hw/rtl/bat_in_if.sv =====
// Input channel: command word with valid/ready handshake.
interface bat_in_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [bat_pkg::IDX_BITS-1:0]   entry_index;
	logic [bat_pkg::POINT_BITS-1:0] point_a;
	logic [bat_pkg::POINT_BITS-1:0] point_b;
	logic [bat_pkg::IDX_BITS-1:0]   start_index;
	logic signed [bat_pkg::MOVE_BITS-1:0] move_count;
	logic                           over_flag;

	modport source (
		output valid, cmd, entry_index, point_a, point_b, start_index, move_count, over_flag,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, point_a, point_b, start_index, move_count, over_flag,
		output ready
	);
endinterface

// ===== hw/rtl/bat_out_if.sv =====
// Output channel: emitted table entry with valid/ready handshake.
interface bat_out_if;
	logic                           valid;
	logic                           ready;
	logic [bat_pkg::IDX_BITS-1:0]   out_index;
	logic [bat_pkg::POINT_BITS-1:0] low_point;
	logic [bat_pkg::POINT_BITS-1:0] high_point;
	logic                           last;
	logic                           bad_request;

	modport source (
		output valid, out_index, low_point, high_point, last, bad_request,
		input  ready
	);
	modport sink (
		input  valid, out_index, low_point, high_point, last, bad_request,
		output ready
	);
endinterface

// ===== hw/rtl/bat_dpath.sv =====
// Datapath: transposition table, braid walk registers and output word register.
module bat_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bat_pkg::LEN_BITS-1:0]   cfg_wdata,
	input  bat_pkg::in_word_t              in_word,
	input  bat_pkg::ctrl_cmd_t             cmd,
	output bat_pkg::ctrl_stat_t            stat,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [bat_pkg::IDX_BITS-1:0]   out_index,
	output logic [bat_pkg::POINT_BITS-1:0] low_point,
	output logic [bat_pkg::POINT_BITS-1:0] high_point,
	output logic                           out_last,
	output logic                           out_bad
);
	import bat_pkg::*;

	pair_t mem [MAX_ENTRIES];
	pair_t rdata_q;

	logic [LEN_BITS-1:0]  len_q;
	logic [IDX_BITS-1:0]  p_q;
	logic [IDX_BITS-1:0]  k_q;
	logic [STEP_BITS-1:0] steps_q;
	logic                 over_q;
	logic                 right_q;
	pair_t                m_q;

	logic                 out_valid_q;
	logic [IDX_BITS-1:0]  out_index_q;
	pair_t                out_pair_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	logic [IDX_BITS-1:0]  nxt;
	logic [IDX_BITS-1:0]  raddr;
	logic [IDX_BITS-1:0]  waddr;
	logic [IDX_BITS-1:0]  bad_idx;
	pair_t                wdata;
	pair_t                in_pair;
	logic [STEP_BITS-1:0] in_steps;

	// neighbor of the moved entry, wrapping at the active length
	always_comb begin
		if (right_q) begin
			nxt = ({1'b0, p_q} + LEN_BITS'(1) == len_q) ? '0 : p_q + IDX_BITS'(1);
		end else begin
			nxt = (p_q == '0) ? IDX_BITS'(len_q - LEN_BITS'(1)) : p_q - IDX_BITS'(1);
		end
	end

	assign in_pair  = order_pair('{lo: in_word.point_a, hi: in_word.point_b});
	assign in_steps = in_word.move_count[MOVE_BITS-1] ?
		STEP_BITS'(-in_word.move_count) : STEP_BITS'(in_word.move_count);
	assign bad_idx  = (in_word.cmd == CMD_BRAID) ? in_word.start_index : in_word.entry_index;

	always_comb begin
		case (cmd.rd_sel)
			RD_START: raddr = in_word.start_index;
			RD_NEXT:  raddr = nxt;
			RD_EMIT:  raddr = k_q;
			default:  raddr = k_q;
		endcase
	end

	always_comb begin
		waddr = p_q;
		case (cmd.wr_sel)
			WR_INPUT: begin
				waddr = in_word.entry_index;
				wdata = in_pair;
			end
			WR_STEP:  wdata = over_q ? rdata_q : conj(rdata_q, m_q);
			WR_MOVED: wdata = m_q;
			default:  wdata = m_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < LEN_MIN) begin
				len_q <= LEN_MIN;
			end else if (cfg_wdata > LEN_MAX) begin
				len_q <= LEN_MAX;
			end else begin
				len_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_braid) begin
			p_q     <= in_word.start_index;
			steps_q <= in_steps;
			over_q  <= in_word.over_flag;
			right_q <= ~in_word.move_count[MOVE_BITS-1];
		end else if (cmd.step) begin
			p_q     <= nxt;
			steps_q <= steps_q - STEP_BITS'(1);
		end
		if (cmd.load_m) begin
			m_q <= rdata_q;
		end else if (cmd.step && over_q) begin
			m_q <= conj(m_q, rdata_q);
		end
		if (cmd.clr_k) begin
			k_q <= '0;
		end else if (cmd.inc_k) begin
			k_q <= k_q + IDX_BITS'(1);
		end
	end

	// output word register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_bad) begin
				out_index_q <= bad_idx;
				out_pair_q  <= '0;
				out_last_q  <= 1'b1;
				out_bad_q   <= 1'b1;
			end else begin
				out_index_q <= k_q;
				out_pair_q  <= rdata_q;
				out_last_q  <= stat.emit_last;
				out_bad_q   <= 1'b0;
			end
		end
	end

	assign stat.cmd        = in_word.cmd;
	assign stat.idx_bad    = {1'b0, bad_idx} >= len_q;
	assign stat.steps_zero = steps_q == '0;
	assign stat.steps_one  = steps_q == STEP_BITS'(1);
	assign stat.emit_last  = {1'b0, k_q} + LEN_BITS'(1) == len_q;
	assign stat.out_busy   = out_valid_q;
	assign stat.out_free   = ~out_valid_q | out_ready;

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign low_point  = out_pair_q.lo;
	assign high_point = out_pair_q.hi;
	assign out_last   = out_last_q;
	assign out_bad    = out_bad_q;

endmodule

// ===== hw/rtl/bat_ctrl.sv =====
// Controller: sequences table writes, braid steps and the emission sweep.
module bat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bat_pkg::ctrl_stat_t stat,
	output bat_pkg::ctrl_cmd_t  cmd
);
	import bat_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_GET_M   = 3'd1;
	localparam logic [2:0] S_STEP_RD = 3'd2;
	localparam logic [2:0] S_STEP_WR = 3'd3;
	localparam logic [2:0] S_FIN     = 3'd4;
	localparam logic [2:0] S_EMIT_RD = 3'd5;
	localparam logic [2:0] S_EMIT_LD = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       fire;

	assign in_ready = (state_q == S_IDLE) && !stat.out_busy;
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_START;
		cmd.wr_sel = WR_INPUT;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					if (stat.idx_bad) begin
						cmd.out_load = 1'b1;
						cmd.out_bad  = 1'b1;
					end else if (stat.cmd == CMD_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.load_braid = 1'b1;
						state_d        = S_GET_M;
					end
				end
			end
			S_GET_M: begin
				// moved entry arrives from the read issued at accept
				cmd.load_m = 1'b1;
				cmd.clr_k  = 1'b1;
				state_d    = stat.steps_zero ? S_EMIT_RD : S_STEP_RD;
			end
			S_STEP_RD: begin
				cmd.rd_sel = RD_NEXT;
				state_d    = S_STEP_WR;
			end
			S_STEP_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_STEP;
				cmd.step   = 1'b1;
				state_d    = stat.steps_one ? S_FIN : S_STEP_RD;
			end
			S_FIN: begin
				// drop the moved entry at its final place
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_MOVED;
				state_d    = S_EMIT_RD;
			end
			S_EMIT_RD: begin
				cmd.rd_sel = RD_EMIT;
				state_d    = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.rd_sel = RD_EMIT;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.inc_k = 1'b1;
						state_d   = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/braid_action_on_transpositions.sv =====
// Braid action on a cyclic table of transpositions: top level.
// Write: no result. Bad index: result valid the cycle after accept; next word accepted once it is taken.
// Braid: fetches the moved entry, then per step a registered read and a write, then places
// the moved entry (none for a zero count), then per emitted entry a registered read and an
// output load that waits while the sink has not taken the previous word.
// Reset clears the controller and output valid, sets active_length to 16; table undefined.
module braid_action_on_transpositions (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bat_pkg::LEN_BITS-1:0] cfg_wdata,
	bat_in_if.sink                       in_ch,
	bat_out_if.source                    out_ch
);
	import bat_pkg::*;

	in_word_t   in_word;
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	logic       in_ready;

	assign in_word.cmd         = in_ch.cmd;
	assign in_word.entry_index = in_ch.entry_index;
	assign in_word.point_a     = in_ch.point_a;
	assign in_word.point_b     = in_ch.point_b;
	assign in_word.start_index = in_ch.start_index;
	assign in_word.move_count  = in_ch.move_count;
	assign in_word.over_flag   = in_ch.over_flag;
	assign in_ch.ready         = in_ready;

	bat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bat_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_word    (in_word),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_index  (out_ch.out_index),
		.low_point  (out_ch.low_point),
		.high_point (out_ch.high_point),
		.out_last   (out_ch.last),
		.out_bad    (out_ch.bad_request)
	);

endmodule
